// File: design/xsf_pkg.sv
package xsf_pkg;

    // Raw configuration field width and APB address width
    localparam int CFG_W  = 11;
    localparam int CFG_AW = 3;

    // Default frame size limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // Register reset values
    localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 11'd320;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd240;

    // Register indexes (paddr[2])
    localparam logic REG_LINE_WIDTH   = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Input item opcodes
    localparam logic OP_PIXEL   = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    // RGB565 field masks
    localparam logic [15:0] RED_MASK = 16'hf800;
    localparam logic [15:0] GRN_MASK = 16'h07e0;
    localparam logic [15:0] BLU_MASK = 16'h001f;

    typedef struct packed {
        logic       op;
        logic [7:0] edge_byte;
        logic [7:0] pal_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_t;

    typedef struct packed {
        logic [15:0] color;
        logic        line_end;
        logic        frame_end;
    } out_t;

    typedef struct packed {
        logic [CFG_W-1:0] line_width;
        logic [CFG_W-1:0] frame_height;
    } cfg_t;

    // Pack 8-bit components down to RGB565
    function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
        logic [15:0] rr;
        logic [15:0] gg;
        logic [15:0] bb;
        rr = {r, 8'h00} & RED_MASK;
        gg = 16'({g, 3'b000}) & GRN_MASK;
        bb = 16'(b >> 3) & BLU_MASK;
        return rr | gg | bb;
    endfunction

endpackage

// File: design/xsf_cfg_regs.sv
module xsf_cfg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [xsf_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output xsf_pkg::cfg_t              cfg
);
    import xsf_pkg::*;

    logic [CFG_W-1:0] line_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    // Register writes on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg   <= LINE_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_LINE_WIDTH:   line_width_reg   <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Readback
    always_comb begin
        case (paddr[2])
            REG_LINE_WIDTH:   prdata = 32'(line_width_reg);
            REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    assign cfg.line_width   = line_width_reg;
    assign cfg.frame_height = frame_height_reg;

endmodule

// File: design/xor_span_fill_palette_out_unit.sv
// XOR span fill with RGB565 palette output.
//
// s_ channel (valid/ready) carries one item per transfer: op 0 is the next
// edge byte of the frame in raster order, op 1 writes one palette entry.
// m_ channel (valid/ready) carries one RGB565 pixel per displayed pixel,
// flagged with line_end and frame_end. The last row of each frame is
// accumulated into the line store but produces no transfer on m_.
// Frame size is set over the APB port: line_width at 0x0, frame_height at
// 0x4; change it only while no item is in flight.
//
// Pipeline: an accepted pixel passes through the stage 1 register, then the
// output register. Throughput: one item per cycle unless a displayed pixel
// waits behind a held output, set by the line store read at accept and the
// palette read one stage later.
// Reset: counters and running XOR clear, all palette entries read as zero
// until written, line_width = 320, frame_height = 240.
// Stall: while m_ready is low the output register holds; s_ready stays high
// until a displayed pixel is waiting behind the held output.
module xor_span_fill_palette_out_unit #(
    parameter int MAX_WIDTH  = xsf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = xsf_pkg::MAX_HEIGHT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [xsf_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  xsf_pkg::in_t               s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output xsf_pkg::out_t              m_data
);
    import xsf_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int WCW = ((WW > CFG_W) ? WW : CFG_W) + 1;
    localparam int HCW = ((HW > CFG_W) ? HW : CFG_W) + 1;

    typedef struct packed {
        logic          op;
        logic [7:0]    edge_byte;
        logic [CW-1:0] col;
        logic          row0;
        logic          shown;
        logic          row_last;
        logic          frame_last;
        logic          fwd;
        logic [7:0]    fwd_data;
        logic [7:0]    pal_index;
        logic [15:0]   pal_color;
    } p1_t;

    cfg_t cfg;

    logic [CW-1:0]  col_reg;
    logic [RW-1:0]  row_reg;
    logic [7:0]     run_reg;
    logic           p1_valid_reg;
    p1_t            p1_reg;
    p1_t            p1_next;
    logic [7:0]     col_rd_reg;
    logic           m_valid_reg;
    out_t           m_data_reg;

    logic [7:0]     col_mem [MAX_WIDTH];
    logic [15:0]    pal_mem [256];
    logic [255:0]   pal_vld_reg;

    logic [WCW-1:0] w_raw, w_eff, col_inc;
    logic [HCW-1:0] h_raw, h_eff, row_inc;
    logic           row_last, row_end, frame_last;
    logic           accept, pix_acc;
    logic [7:0]     col_val, acc;
    logic           p1_pix, p1_out, p1_leave;

    xsf_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Clamp frame size: zero acts as one, above the limit acts as the limit
    always_comb begin
        w_raw = WCW'(cfg.line_width);
        h_raw = HCW'(cfg.frame_height);
        if (w_raw == '0)                 w_eff = WCW'(1);
        else if (w_raw > WCW'(MAX_WIDTH)) w_eff = WCW'(MAX_WIDTH);
        else                             w_eff = w_raw;
        if (h_raw == '0)                  h_eff = HCW'(1);
        else if (h_raw > HCW'(MAX_HEIGHT)) h_eff = HCW'(MAX_HEIGHT);
        else                              h_eff = h_raw;
    end

    // Position flags of the pixel at the input
    assign col_inc    = WCW'(col_reg) + WCW'(1);
    assign row_inc    = HCW'(row_reg) + HCW'(1);
    assign row_last   = (col_inc >= w_eff);
    assign row_end    = (row_inc >= h_eff);
    assign frame_last = row_last && ((row_inc + HCW'(1)) >= h_eff);

    // Stage 1: accumulate, then either leave quietly or load the output
    assign col_val  = p1_reg.fwd ? p1_reg.fwd_data : col_rd_reg;
    assign acc      = p1_reg.edge_byte ^ (p1_reg.row0 ? run_reg : col_val);
    assign p1_pix   = p1_valid_reg && (p1_reg.op == OP_PIXEL);
    assign p1_out   = p1_pix && p1_reg.shown;
    assign p1_leave = p1_valid_reg && (!p1_out || !m_valid_reg || m_ready);

    assign s_ready = !p1_valid_reg || p1_leave;
    assign accept  = s_valid && s_ready;
    assign pix_acc = accept && (s_data.op == OP_PIXEL);

    // Stage 1 payload; forward the leaving pixel when it hits the same column
    always_comb begin
        p1_next.op         = s_data.op;
        p1_next.edge_byte  = s_data.edge_byte;
        p1_next.col        = col_reg;
        p1_next.row0       = (row_reg == '0);
        p1_next.shown      = !row_end;
        p1_next.row_last   = row_last;
        p1_next.frame_last = frame_last;
        p1_next.fwd        = p1_pix && (p1_reg.col == col_reg);
        p1_next.fwd_data   = acc;
        p1_next.pal_index  = s_data.pal_index;
        p1_next.pal_color  = pack565(s_data.red, s_data.green, s_data.blue);
    end

    // Pixel position counters, advanced at accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (pix_acc) begin
            if (row_last) begin
                col_reg <= '0;
                row_reg <= row_end ? '0 : RW'(row_inc);
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // Stage 1 valid and payload
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_leave) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_reg <= p1_next;
        end
    end

    // Row 0 running XOR
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= '0;
        end else if (p1_pix && p1_leave) begin
            if (p1_reg.row_last) begin
                run_reg <= '0;
            end else if (p1_reg.row0) begin
                run_reg <= acc;
            end
        end
    end

    // Line store: read at accept, written as the pixel leaves stage 1
    always_ff @(posedge aclk) begin
        if (p1_pix && p1_leave) begin
            col_mem[p1_reg.col] <= acc;
        end
        if (pix_acc) begin
            col_rd_reg <= col_mem[col_reg];
        end
    end

    // Palette store and its written flags
    always_ff @(posedge aclk) begin
        if (p1_leave && (p1_reg.op == OP_PALETTE)) begin
            pal_mem[p1_reg.pal_index] <= p1_reg.pal_color;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pal_vld_reg <= '0;
        end else if (p1_leave && (p1_reg.op == OP_PALETTE)) begin
            pal_vld_reg[p1_reg.pal_index] <= 1'b1;
        end
    end

    // Output register, loaded with the palette read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_out && p1_leave) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_out && p1_leave) begin
            m_data_reg.color     <= pal_vld_reg[acc] ? pal_mem[acc] : '0;
            m_data_reg.line_end  <= p1_reg.row_last;
            m_data_reg.frame_end <= p1_reg.frame_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The column counter never leaves the line store
    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ({1'b0, col_reg} < (CW + 1)'(MAX_WIDTH)))
        else $error("column counter out of range");

    // Within a row the column advances by one per pixel
    a_col_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (pix_acc && !row_last) |=> (col_reg == $past(col_reg) + 1'b1))
        else $error("column counter skipped");

    // A frame end is always also a line end
    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_end) |-> m_data.line_end)
        else $error("frame_end without line_end");

    // A draining receiver never throttles the input
    a_no_throttle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import xsf_pkg::*;

    localparam int MAX_W = MAX_WIDTH_DEF;
    localparam int MAX_H = MAX_HEIGHT_DEF;

    // Clock, reset and block ports
    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [CFG_AW-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_t               s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_t              m_data;

    // Pending items for the driver, colors still owed by the block
    in_t  pending[$];
    out_t colors_due[$];
    bit   s_taken = 1'b0;
    int unsigned src_idle = 26;
    int unsigned snk_idle = 57;

    // Shadow of the block: size registers, line store, counters and palette
    logic [CFG_W-1:0] cfg_width  = LINE_WIDTH_RST;
    logic [CFG_W-1:0] cfg_height = FRAME_HEIGHT_RST;
    logic [7:0]       line_mem[MAX_W];
    bit               col_written[MAX_W];
    logic [15:0]      palette_mem[256];
    logic [7:0]       row_xor = '0;
    int unsigned      cur_col = 0;
    int unsigned      cur_row = 0;

    int unsigned n_err = 0;
    int unsigned n_pixels = 0;
    int unsigned n_palette = 0;
    int unsigned n_colors = 0;
    int unsigned n_cfg = 0;

    xor_span_fill_palette_out_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        foreach (palette_mem[i]) palette_mem[i] = '0;
        foreach (line_mem[i]) begin
            line_mem[i]    = '0;
            col_written[i] = 1'b0;
        end
    end

    // Out-of-range sizes: 0 behaves as 1, anything past the maximum as the maximum
    function automatic int unsigned dim_eff(input logic [CFG_W-1:0] raw, input int unsigned maxv);
        if (raw == 0) return 1;
        if (raw > maxv) return maxv;
        return 32'(raw);
    endfunction

    // Number of leading columns of the line store written since reset
    function automatic int unsigned stored_prefix();
        int unsigned n = 0;
        while (n < MAX_W && col_written[n]) n++;
        return n;
    endfunction

    // Advance the shadow by one accepted item; queue the color it owes, if any
    task automatic span_fill_step(input in_t it);
        int unsigned w;
        int unsigned h;
        logic [7:0]  acc;
        bit          row_done;
        out_t        o;
        if (it.op == OP_PALETTE) begin
            palette_mem[it.pal_index] = {it.red[7:3], it.green[7:2], it.blue[7:3]};
            n_palette++;
            return;
        end
        n_pixels++;
        w = dim_eff(cfg_width, MAX_W);
        h = dim_eff(cfg_height, MAX_H);
        if (cur_row == 0) begin
            acc     = it.edge_byte ^ row_xor;
            row_xor = acc;
        end else begin
            acc = it.edge_byte ^ line_mem[cur_col];
        end
        line_mem[cur_col]    = acc;
        col_written[cur_col] = 1'b1;
        row_done = (cur_col + 1 >= w);
        // last row of the frame is accumulated only
        if (cur_row + 1 < h) begin
            o.color     = palette_mem[acc];
            o.line_end  = row_done;
            o.frame_end = row_done && (cur_row + 2 >= h);
            colors_due.push_back(o);
        end
        if (row_done) begin
            cur_col = 0;
            row_xor = '0;
            cur_row = (cur_row + 1 >= h) ? 0 : cur_row + 1;
        end else begin
            cur_col++;
        end
    endtask

    // Monitor: check output transfers, then feed accepted input transfers to the shadow
    always @(posedge aclk) begin
        out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_colors++;
                if (colors_due.size() == 0) begin
                    n_err++;
                    if (n_err <= 200)
                        $display("%0t: unexpected output transfer color=%h line_end=%b frame_end=%b",
                                 $time, m_data.color, m_data.line_end, m_data.frame_end);
                end else begin
                    want = colors_due.pop_front();
                    if (m_data.color !== want.color || m_data.line_end !== want.line_end ||
                        m_data.frame_end !== want.frame_end) begin
                        n_err++;
                        if (n_err <= 200)
                            $display("%0t: expected color=%h line_end=%b frame_end=%b got %h %b %b",
                                     $time, want.color, want.line_end, want.frame_end,
                                     m_data.color, m_data.line_end, m_data.frame_end);
                    end
                end
            end
            if (s_valid && s_ready) begin
                span_fill_step(s_data);
                s_taken = 1'b1;
            end
        end
    end

    // Driver: present the next pending item and toggle m_ready, both at the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_taken) begin
                if (pending.size() != 0 && $urandom_range(99) >= src_idle) begin
                    s_data  <= pending.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            s_taken = 1'b0;
        end
        m_ready <= ($urandom_range(99) >= snk_idle);
    end

    function automatic void queue_pixel(input logic [7:0] e);
        in_t it;
        it           = in_t'({$urandom, $urandom});
        it.op        = OP_PIXEL;
        it.edge_byte = e;
        pending.push_back(it);
    endfunction

    function automatic void queue_palette(input logic [7:0] idx, input logic [7:0] r,
                                          input logic [7:0] g, input logic [7:0] b);
        in_t it;
        it           = in_t'({$urandom, $urandom});
        it.op        = OP_PALETTE;
        it.pal_index = idx;
        it.red       = r;
        it.green     = g;
        it.blue      = b;
        pending.push_back(it);
    endfunction

    // Hold off until every item is taken and every color delivered, then let the pipe drain
    task automatic wait_quiet();
        do @(negedge aclk); while (pending.size() != 0 || s_valid || colors_due.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    // APB write: setup phase, then access phase
    task automatic apb_write(input logic reg_sel, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {{(32-CFG_W){1'b0}}, val};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_LINE_WIDTH) cfg_width = val;
        else cfg_height = val;
        n_cfg++;
    endtask

    // Resize while idle; mid-frame the width never reaches columns the line store lacks
    task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        wait_quiet();
        if (cur_row != 0 && dim_eff(w, MAX_W) > stored_prefix())
            w = CFG_W'(stored_prefix());
        apb_write(REG_LINE_WIDTH, w);
        apb_write(REG_FRAME_HEIGHT, h);
    endtask

    function automatic logic [CFG_W-1:0] pick_dim();
        int unsigned r = $urandom_range(99);
        if (r < 4) return '0;
        if (r < 8) return CFG_W'(1);
        if (r < 11) return CFG_W'(MAX_W);
        if (r < 13) return '1;
        if (r < 17) return CFG_W'($urandom_range(2047));
        return CFG_W'($urandom_range(9, 2));
    endfunction

    // Stimulus
    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset size and cleared palette, then palette extremes
        @(posedge aclk);
        queue_pixel(8'h00);
        queue_pixel(8'hff);
        queue_palette(8'hff, 8'hff, 8'hff, 8'hff);
        queue_palette(8'h00, 8'h07, 8'h03, 8'h07);
        queue_palette(8'h5a, 8'hf8, 8'hfc, 8'hf8);
        queue_palette(8'ha5, 8'h80, 8'h40, 8'h08);

        // 4x3 frame, palette write in the middle of a row
        set_size(11'd4, 11'd3);
        @(posedge aclk);
        queue_pixel(8'h5a);
        queue_pixel(8'hff);
        queue_pixel(8'h00);
        queue_pixel(8'h0f);
        queue_palette(8'h0f, 8'h12, 8'h34, 8'h56);
        queue_pixel(8'hf0);
        queue_pixel(8'h55);
        repeat (4) queue_pixel(8'($urandom_range(255)));
        queue_pixel(8'haa);
        queue_pixel(8'h55);
        queue_pixel(8'h11);
        queue_pixel(8'h22);
        queue_pixel(8'h33);
        queue_pixel(8'h44);
        queue_pixel(8'h80);

        // Width cut mid-row: the current column is past the new width and ends the row
        set_size(11'd2, 11'd3);
        @(posedge aclk);
        queue_pixel(8'h01);
        queue_pixel(8'h10);
        queue_pixel(8'h20);

        // Single-row frame: nothing shown
        set_size(11'd0, 11'd0);
        @(posedge aclk);
        queue_pixel(8'h7e);
        queue_pixel(8'h81);

        // Oversized registers clamp to the maximum
        set_size(11'h7ff, 11'h7ff);
        @(posedge aclk);
        queue_pixel(8'hc3);
        queue_pixel(8'h3c);

        // Height cut below the current row: rest of the row is silent
        set_size(11'd3, 11'h7ff);
        @(posedge aclk);
        queue_pixel(8'h99);
        queue_pixel(8'h01);
        set_size(11'd3, 11'd1);
        @(posedge aclk);
        queue_pixel(8'h02);
        queue_pixel(8'h03);

        // Random frames under three idling mixes, pausing for a drain between batches
        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 26 : (ph == 1) ? 57 : 0;
            snk_idle = (ph == 0) ? 57 : (ph == 1) ? 26 : 0;
            for (int seg = 0; seg < 10; seg++) begin
                if ($urandom_range(99) < 70) set_size(pick_dim(), pick_dim());
                else wait_quiet();
                @(posedge aclk);
                repeat ($urandom_range(70, 36)) begin
                    if ($urandom_range(99) < 15)
                        queue_palette(8'($urandom_range(255)), 8'($urandom_range(255)),
                                      8'($urandom_range(255)), 8'($urandom_range(255)));
                    else
                        queue_pixel(8'($urandom_range(255)));
                end
            end
        end

        wait_quiet();
        repeat (8) @(negedge aclk);
        $display("Run covered %0d pixels and %0d palette writes over %0d register writes;",
                 n_pixels, n_palette, n_cfg);
        $display("%0d colors checked, %0d mismatches.", n_colors, n_err);
        if (n_err == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Timeout with %0d items pending and %0d colors owed",
                 pending.size(), colors_due.size());
        $display("Verification failed");
        $finish;
    end

endmodule

// File: xor_span_fill_palette_out_unit.f
design/xsf_pkg.sv
design/xsf_cfg_regs.sv
design/xor_span_fill_palette_out_unit.sv
verif/testbench.sv
